// ===== sv/riscv_trap_entry_unit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Trap entry unit assertion macros
// Shared concurrent assertion forms for the trap entry unit.
// ----------------------------------------------------------------------------
`ifndef RISCV_TRAP_ENTRY_UNIT_CORE_MACROS_SVH
`define RISCV_TRAP_ENTRY_UNIT_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define RTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("trap entry unit check failed");

// Next-cycle implication, checked only out of reset.
`define RTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("trap entry unit check failed");

`endif

// ===== sv/rte_pkg.sv =====
// ----------------------------------------------------------------------------
// Trap entry unit package
// Types, codes and field layout shared by the trap entry unit modules.
// ----------------------------------------------------------------------------
package rte_pkg;

    typedef enum logic [1:0] {
        FUNC_TRAP  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_LOAD  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_MACHINE_VECTOR = 3'd0,
        CFG_SUPER_VECTOR   = 3'd1,
        CFG_IRQ_DELEG      = 3'd2,
        CFG_EXC_DELEG      = 3'd3,
        CFG_IRQ_ENABLES    = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;

    localparam int IRQ_SSOFT = 1;
    localparam int IRQ_MTIP  = 7;
    localparam int IRQ_SEXT  = 9;

    localparam logic [31:0] CAUSE_S_SOFT = 32'h8000_0001;
    localparam logic [31:0] CAUSE_TIMER  = 32'h8000_0007;
    localparam logic [31:0] CAUSE_S_EXT  = 32'h8000_0009;

    localparam int IN_W  = 168;
    localparam int OUT_W = 104;

    // input tdata layout
    localparam int IN_CAUSE = 0;
    localparam int IN_PC    = 32;
    localparam int IN_TVAL  = 64;
    localparam int IN_PEND  = 96;
    localparam int IN_TREQ  = 128;
    localparam int IN_NSTAT = 129;
    localparam int IN_NPRIV = 161;

    typedef struct packed {
        logic [31:0] machine_vector;
        logic [31:0] super_vector;
        logic [31:0] irq_deleg;
        logic [31:0] exc_deleg;
        logic [31:0] irq_enables;
    } t_cfg;

    typedef struct packed {
        logic [31:0] status;
        logic [1:0]  priv;
        logic        timer_latch;
    } t_csr_state;

    typedef struct packed {
        logic [31:0] trap_cause;
        logic [31:0] fault_pc;
        logic [31:0] fault_value;
        logic [31:0] pending_lines;
        logic        timer_request;
        logic [31:0] new_status;
        logic [1:0]  new_privilege;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  privilege_now;
        logic [31:0] status_now;
        logic [31:0] irq_cause;
        logic        irq_found;
        logic        to_supervisor;
        logic [31:0] handler_pc;
    } t_result;

    typedef struct packed {
        logic [31:0] cause;
        logic [31:0] return_pc;
        logic [31:0] trap_value;
    } t_trap_save;

endpackage

// ===== sv/rte_trap_logic.sv =====
// ----------------------------------------------------------------------------
// Trap entry next-state logic
// Computes the next CSR state and the result word for one transaction.
// ----------------------------------------------------------------------------
module rte_trap_logic
    import rte_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_csr_state i_state,
    input  t_func      i_func,
    input  t_in_item   i_item,
    output t_csr_state o_state,
    output t_result    o_result,
    output logic       o_save_m,
    output logic       o_save_s
);

    logic [31:0] cause_mask;
    logic        deleg;
    logic [31:0] act;
    logic        mie;
    logic        sie;
    logic        latch_set;
    logic [31:0] st_s;
    logic [31:0] st_m;

    assign cause_mask = i_item.trap_cause[31] ? i_cfg.irq_deleg : i_cfg.exc_deleg;
    assign deleg      = cause_mask[i_item.trap_cause[4:0]] && (i_state.priv != PRIV_M);
    assign act        = i_item.pending_lines & i_cfg.irq_enables;
    assign mie        = i_state.status[ST_MIE];
    assign sie        = i_state.status[ST_SIE];
    assign latch_set  = i_state.timer_latch | i_item.timer_request;

    always_comb begin
        st_s          = i_state.status;
        st_s[ST_SPIE] = i_state.status[ST_SIE];
        st_s[ST_SIE]  = 1'b0;
        st_s[ST_SPP]  = (i_state.priv == PRIV_S);
        st_m          = i_state.status;
        st_m[ST_MPIE] = i_state.status[ST_MIE];
        st_m[ST_MIE]  = 1'b0;
        st_m[ST_MPP+1:ST_MPP] = i_state.priv;
    end

    always_comb begin
        o_state             = i_state;
        o_state.timer_latch = latch_set;
        o_result            = '0;
        o_save_m            = 1'b0;
        o_save_s            = 1'b0;
        case (i_func)
            FUNC_TRAP: begin
                if (deleg) begin
                    o_state.status         = st_s;
                    o_state.priv           = PRIV_S;
                    o_result.handler_pc    = i_cfg.super_vector;
                    o_result.to_supervisor = 1'b1;
                    o_save_s               = 1'b1;
                end else begin
                    o_state.status      = st_m;
                    o_state.priv        = PRIV_M;
                    o_result.handler_pc = i_cfg.machine_vector;
                    o_save_m            = 1'b1;
                end
            end
            FUNC_QUERY: begin
                if (act[IRQ_MTIP] && mie) begin
                    o_result.irq_cause = CAUSE_TIMER;
                end else if (latch_set && mie) begin
                    o_state.timer_latch = 1'b0;
                    o_result.irq_cause  = CAUSE_TIMER;
                end else if (act[IRQ_SSOFT] && sie) begin
                    o_result.irq_cause = CAUSE_S_SOFT;
                end else if (act[IRQ_SEXT] && sie) begin
                    o_result.irq_cause = CAUSE_S_EXT;
                end
                o_result.irq_found = (o_result.irq_cause != '0);
            end
            FUNC_LOAD: begin
                o_state.status = i_item.new_status;
                o_state.priv   = i_item.new_privilege;
            end
            default: begin
            end
        endcase
        o_result.status_now    = o_state.status;
        o_result.privilege_now = o_state.priv;
    end

endmodule

// ===== sv/riscv_trap_entry_unit_core.sv =====
// ----------------------------------------------------------------------------
// RV32 trap entry unit with supervisor delegation
// The result is registered when the input transaction is accepted.
// Throughput: one transaction per cycle unless the skid entry is full; the CSR
//   update is one pass of mask/mux logic from the CSRs to the result register.
// A two-entry output buffer keeps input acceptance going while a result waits.
// Reset (synchronous, active low): status 0, privilege M, timer latch clear,
//   configuration registers 0, output buffer empty.
// ----------------------------------------------------------------------------
module riscv_trap_entry_unit_core
    import rte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [31:0] trap_cause, [63:32] fault_pc, [95:64] fault_value,
    // [127:96] pending_lines, [128] timer_request, [160:129] new_status,
    // [162:161] new_privilege, [167:163] zero
    input  logic [IN_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [31:0] handler_pc, [32] to_supervisor, [33] irq_found,
    // [65:34] irq_cause, [97:66] status_now, [99:98] privilege_now, [103:100] zero
    output logic [OUT_W-1:0] m_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

    t_cfg        r_cfg;
    t_csr_state  r_state;
    t_csr_state  n_state;
    t_trap_save  r_save_m;
    t_trap_save  r_save_s;
    t_in_item    item;
    t_result     result;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        save_m;
    logic        save_s;
    logic        accept;
    logic        take;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !r_skid_valid;
    assign accept      = s_tvalid && s_tready;
    assign take        = r_out_valid && m_tready;

    assign item.trap_cause    = s_tdata[IN_CAUSE +: 32];
    assign item.fault_pc      = s_tdata[IN_PC +: 32];
    assign item.fault_value   = s_tdata[IN_TVAL +: 32];
    assign item.pending_lines = s_tdata[IN_PEND +: 32];
    assign item.timer_request = s_tdata[IN_TREQ];
    assign item.new_status    = s_tdata[IN_NSTAT +: 32];
    assign item.new_privilege = s_tdata[IN_NPRIV +: 2];

    rte_trap_logic u_trap_logic (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_func   (t_func'(s_tuser)),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (result),
        .o_save_m (save_m),
        .o_save_s (save_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MACHINE_VECTOR: r_cfg.machine_vector <= i_cfg_data;
                CFG_SUPER_VECTOR:   r_cfg.super_vector   <= i_cfg_data;
                CFG_IRQ_DELEG:      r_cfg.irq_deleg      <= i_cfg_data;
                CFG_EXC_DELEG:      r_cfg.exc_deleg      <= i_cfg_data;
                CFG_IRQ_ENABLES:    r_cfg.irq_enables    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.status      <= '0;
            r_state.priv        <= PRIV_M;
            r_state.timer_latch <= 1'b0;
            r_save_m            <= '0;
            r_save_s            <= '0;
        end else if (accept) begin
            r_state <= n_state;
            if (save_m) begin
                r_save_m <= '{item.trap_cause, item.fault_pc, item.fault_value};
            end
            if (save_s) begin
                r_save_s <= '{item.trap_cause, item.fault_pc, item.fault_value};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_skid_valid) begin
            r_out <= r_skid;
        end else if (accept && (take || !r_out_valid)) begin
            r_out <= result;
        end
        if (accept && r_out_valid && !take) begin
            r_skid <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

    // saved cause, return PC and trap value have no read port; this XOR keeps them in use
    logic unused_save;
    assign unused_save = ^{r_save_m, r_save_s};

    `include "riscv_trap_entry_unit_core_macros.svh"

    `RTE_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `RTE_ASSERT_NEXT(a_load_priv, i_clk, i_rst_n, accept && (s_tuser == FUNC_LOAD),
        r_state.priv == $past(s_tdata[IN_NPRIV +: 2]))
    `RTE_ASSERT_NEXT(a_trap_priv, i_clk, i_rst_n, accept && (s_tuser == FUNC_TRAP),
        (r_state.priv == PRIV_M) || (r_state.priv == PRIV_S))
    `RTE_ASSERT_NEXT(a_timer_latch, i_clk, i_rst_n,
        accept && s_tdata[IN_TREQ] && (s_tuser != FUNC_QUERY), r_state.timer_latch)

endmodule
